/* rtl/psbcd_pkg.sv */
// Package: shared types, constants and helpers of the bank conflict degree block.
`timescale 1ns / 1ps
package psbcd_pkg;

  // Lanes per warp access and the bank geometry
  localparam int LANES  = 32;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W  = $clog2(LANES + 1);
  localparam int BANKS  = 32;
  localparam int BANK_W = 5;
  // Offset bits that matter: bank bits plus the low bank bits of the row number
  localparam int OFF_W  = 2 * BANK_W;

  // Field widths
  localparam int WARP_W = 5;
  localparam int CFG_W  = 6;
  localparam int RES_W  = 6;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VPT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] VPT_RESET    = 6'd1;
  localparam logic [CFG_W-1:0] STRIDE_RESET = 6'd32;

  // One queued warp access
  typedef struct packed {
    logic [WARP_W-1:0] warp_index;
    logic              last_warp;
  } psbcd_item_t;

  // Queue to engine handshake
  typedef struct packed {
    logic        valid;
    psbcd_item_t item;
  } psbcd_qhead_t;

  // Saturate a lane count to the result width
  function automatic logic [RES_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+RES_W-1:0] wide;
    wide = {{RES_W{1'b0}}, c};
    if (wide > (CNT_W + RES_W)'({RES_W{1'b1}})) begin
      sat_count = {RES_W{1'b1}};
    end else begin
      sat_count = wide[RES_W-1:0];
    end
  endfunction

endpackage

/* rtl/psbcd_queue.sv */
// Front end: two-entry queue that accepts warp access transactions.
`timescale 1ns / 1ps
module psbcd_queue import psbcd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  psbcd_item_t  in_item,
  output psbcd_qhead_t head,
  input  logic         pop
);

  psbcd_item_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        do_pop;

  assign in_stall   = (count_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

/* rtl/psbcd_engine.sv */
// Back end: walks the lanes of one warp access, counts bank hits, drives results.
`timescale 1ns / 1ps
module psbcd_engine import psbcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  psbcd_qhead_t      head,
  output logic              pop,
  input  logic [CFG_W-1:0]  vpt,
  input  logic [CFG_W-1:0]  stride,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RES_W-1:0]  out_warp_conflict,
  output logic [RES_W-1:0]  out_max_conflict,
  output logic              out_final_result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic [OFF_W-1:0]  offset_r, offset_nxt;
  logic [CNT_W-1:0]  counts_r [BANKS];
  logic [CNT_W-1:0]  worst_r, worst_nxt;
  logic              last_r, last_nxt;
  logic [RES_W-1:0]  run_max_r, run_max_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]  warp_r, max_r;
  logic              final_r;

  logic [2*BANK_W-1:0] pad_prod;
  logic [BANK_W-1:0]   bank;
  logic [CNT_W-1:0]    hit_cnt;
  logic [RES_W-1:0]    worst_sat;
  logic [RES_W-1:0]    total;
  logic                out_free;
  logic                finish;

  // Bank of the current lane: padding is stride minus 32, so only its low bits matter
  assign pad_prod  = stride[BANK_W-1:0] * offset_r[OFF_W-1:BANK_W];
  assign bank      = offset_r[BANK_W-1:0] + pad_prod[BANK_W-1:0];
  assign hit_cnt   = counts_r[bank] + CNT_W'(1);

  assign worst_sat = sat_count(worst_r);
  assign total     = (run_max_r > worst_sat) ? run_max_r : worst_sat;
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_IDLE) && head.valid;
  assign finish    = (state_r == ST_DONE) && out_free;

  // Sequence load, lane walk and result hand-off
  always_comb begin
    state_nxt   = state_r;
    lane_nxt    = lane_r;
    offset_nxt  = offset_r;
    worst_nxt   = worst_r;
    last_nxt    = last_r;
    run_max_nxt = run_max_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          state_nxt  = ST_RUN;
          lane_nxt   = '0;
          offset_nxt = OFF_W'(head.item.warp_index);
          worst_nxt  = '0;
          last_nxt   = head.item.last_warp;
        end
      end
      ST_RUN: begin
        offset_nxt = offset_r + OFF_W'(vpt);
        lane_nxt   = lane_r + LANE_W'(1);
        if (hit_cnt > worst_r) begin
          worst_nxt = hit_cnt;
        end
        if (lane_r == LANE_W'(LANES - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt   = ST_IDLE;
          run_max_nxt = last_r ? '0 : total;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Drop a taken result, load a finished one
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_max_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_max_r   <= run_max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    lane_r   <= lane_nxt;
    offset_r <= offset_nxt;
    worst_r  <= worst_nxt;
    last_r   <= last_nxt;
  end

  // Bank hit counters: clear on load, bump one bank per lane
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int b = 0; b < BANKS; b++) begin
        counts_r[b] <= '0;
      end
    end else if (state_r == ST_RUN) begin
      counts_r[bank] <= hit_cnt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (finish) begin
      warp_r  <= worst_sat;
      max_r   <= total;
      final_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_warp_conflict = warp_r;
  assign out_max_conflict  = max_r;
  assign out_final_result  = final_r;

endmodule

/* rtl/padded_stride_bank_conflict_degree.sv */
// Top level: bank conflict degree of padded strided warp accesses.
// Flow: the queue registers each transaction, the engine loads it from the queue head,
//   walks the LANES = 32 lanes updating one bank hit counter per cycle and fills the
//   output register before it loads the next; the two-entry queue takes input meanwhile.
// Reset (rst_n low, synchronous): values_per_thread = 1, row_stride = 32,
//   running maximum cleared, queue and output register empty.
`timescale 1ns / 1ps
module padded_stride_bank_conflict_degree import psbcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WARP_W-1:0]    in_warp_index,
  input  logic                 in_last_warp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RES_W-1:0]     out_warp_conflict,
  output logic [RES_W-1:0]     out_max_conflict,
  output logic                 out_final_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] vpt_r, vpt_nxt;
  logic [CFG_W-1:0] stride_r, stride_nxt;
  psbcd_item_t      in_item;
  psbcd_qhead_t     head;
  logic             pop;

  assign cfg_ready = 1'b1;

  // Configuration registers; other indexes are ignored
  always_comb begin
    vpt_nxt    = vpt_r;
    stride_nxt = stride_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VPT:    vpt_nxt    = cfg_data;
        CFG_STRIDE: stride_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpt_r    <= VPT_RESET;
      stride_r <= STRIDE_RESET;
    end else begin
      vpt_r    <= vpt_nxt;
      stride_r <= stride_nxt;
    end
  end

  assign in_item.warp_index = in_warp_index;
  assign in_item.last_warp  = in_last_warp;

  psbcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  psbcd_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .vpt               (vpt_r),
    .stride            (stride_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_warp_conflict (out_warp_conflict),
    .out_max_conflict  (out_max_conflict),
    .out_final_result  (out_final_result)
  );

  // Running maximum never falls below this warp's conflict
  a_max_ge_warp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_max_conflict >= out_warp_conflict))
    else $error("max_conflict below warp_conflict");

  // Every warp has at least one lane in some bank
  a_warp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_warp_conflict != '0))
    else $error("warp_conflict is zero");

  // A full queue always presents an item to the engine
  a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> head.valid)
    else $error("queue stalls input while empty");

endmodule
